// File: rtl/ptid_pkg.sv
package ptid_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDEF = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Result kinds.
  localparam logic [2:0] K_DP   = 3'd0;
  localparam logic [2:0] K_MOVW = 3'd1;
  localparam logic [2:0] K_MOVT = 3'd2;
  localparam logic [2:0] K_SBFX = 3'd3;
  localparam logic [2:0] K_UBFX = 3'd4;
  localparam logic [2:0] K_BFI  = 3'd5;
  localparam logic [2:0] K_BFC  = 3'd6;

  // Data-processing opcodes.
  localparam logic [3:0] DP_NONE = 4'd0;
  localparam logic [3:0] DP_SUB  = 4'd2;
  localparam logic [3:0] DP_ADD  = 4'd4;

  // Op field (instruction bits 24:20) encodings.
  localparam logic [4:0] SEL_ADD   = 5'h00;
  localparam logic [4:0] SEL_SUB   = 5'h0A;
  localparam logic [4:0] SEL_MOVW  = 5'h04;
  localparam logic [4:0] SEL_MOVT  = 5'h0C;
  localparam logic [4:0] SEL_SBFX  = 5'h14;
  localparam logic [4:0] SEL_UBFX  = 5'h1C;
  localparam logic [4:0] SEL_BFI   = 5'h16;
  localparam logic [4:0] SEL_SSAT  = 5'h10;
  localparam logic [4:0] SEL_SSAT16 = 5'h12;
  localparam logic [4:0] SEL_USAT  = 5'h18;
  localparam logic [4:0] SEL_USAT16 = 5'h1A;

  // Special register numbers.
  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam logic [6:0] WORD_BITS = 7'd32;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  place_kind;
    logic [3:0]  dp_opcode;
    logic [3:0]  dest_reg;
    logic [3:0]  src_reg;
    logic [31:0] immediate;
    logic [4:0]  field_lsb;
    logic [5:0]  field_width;
  } result_t;

endpackage

// File: rtl/ptid_if.sv
interface ptid_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  logic [31:0] fetch_addr;

  modport source (output valid, output instr_word, output fetch_addr, input ready);
  modport sink (input valid, input instr_word, input fetch_addr, output ready);
endinterface

interface ptid_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  place_kind;
  logic [3:0]  dp_opcode;
  logic [3:0]  dest_reg;
  logic [3:0]  src_reg;
  logic [31:0] immediate;
  logic [4:0]  field_lsb;
  logic [5:0]  field_width;

  modport source (
    output valid, output status, output place_kind, output dp_opcode,
    output dest_reg, output src_reg, output immediate, output field_lsb,
    output field_width, input ready
  );
  modport sink (
    input valid, input status, input place_kind, input dp_opcode,
    input dest_reg, input src_reg, input immediate, input field_lsb,
    input field_width, output ready
  );
endinterface

// File: rtl/thumb2_plain_immediate_decoder.sv
// Decoder for the Thumb-2 data-processing plain binary immediate space.
// The input channel carries one 32-bit instruction word (first halfword in
// bits 31:16) and the address it was fetched from. The result channel
// carries one decoded record per word: status, form, opcode, registers,
// immediate (or ADR address, or bitfield insert mask) and bitfield geometry.
// Each word gives exactly one result, in order.
// A word transferred on the input is captured in the input register, decoded by
// shallow logic, and moves into the result register once that register is free,
// where it is offered on the output channel.
// Throughput is one word per cycle while the receiver takes results; the two
// registers form a two-stage pipeline, so a new word is taken while earlier
// ones are in flight. When the receiver stalls, the result register holds its
// contents and the input register fills behind it; the input side stops taking
// words only once both stages are full. Ready on the input depends
// combinationally on ready at the output.
// Reset (rst_n low at a clock edge) empties both stages; no results are
// offered until new words arrive.
module thumb2_plain_immediate_decoder (
  input  logic              clk,
  input  logic              rst_n,
  ptid_in_if.sink           in_ch,
  ptid_out_if.source        out_ch
);

  // Stage one: captured instruction word and address.
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  logic [31:0] instr_r;
  logic [31:0] addr_r;

  // Stage two: decoded result waiting for transfer.
  logic              s2_valid_r;
  logic              s2_valid_nxt;
  ptid_pkg::result_t res_r;
  ptid_pkg::result_t dec_res;

  logic s2_free;
  logic s1_free;
  logic in_take;

  // Stage two can load when it is empty or its result leaves this cycle.
  assign s2_free = !s2_valid_r || out_ch.ready;
  // Stage one can load when it is empty or its word moves on to stage two.
  assign s1_free = !s1_valid_r || s2_free;
  assign in_take = in_ch.valid && s1_free;

  assign in_ch.ready = s1_free;

  ptid_decode u_decode (
    .instr_word (instr_r),
    .fetch_addr (addr_r),
    .result     (dec_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (s1_free) begin
      s1_valid_nxt = in_ch.valid;
    end
    if (s2_free) begin
      s2_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers carry no reset; the valid bits qualify them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      instr_r <= in_ch.instr_word;
      addr_r  <= in_ch.fetch_addr;
    end
    if (s2_free && s1_valid_r) begin
      res_r <= dec_res;
    end
  end

  assign out_ch.valid       = s2_valid_r;
  assign out_ch.status      = res_r.status;
  assign out_ch.place_kind  = res_r.place_kind;
  assign out_ch.dp_opcode   = res_r.dp_opcode;
  assign out_ch.dest_reg    = res_r.dest_reg;
  assign out_ch.src_reg     = res_r.src_reg;
  assign out_ch.immediate   = res_r.immediate;
  assign out_ch.field_lsb   = res_r.field_lsb;
  assign out_ch.field_width = res_r.field_width;

endmodule

// File: rtl/ptid_decode.sv
module ptid_decode (
  input  logic [31:0]      instr_word,
  input  logic [31:0]      fetch_addr,
  output ptid_pkg::result_t result
);

  logic [4:0]  sel;
  logic [3:0]  rn;
  logic [3:0]  rd;
  logic [11:0] imm12;
  logic [4:0]  bf_lsb;
  logic [4:0]  bf_msb;
  logic [5:0]  sx_width;
  logic [6:0]  sx_end;
  logic [5:0]  bf_width;
  logic [31:0] adr_base;
  logic [31:0] bf_mask;
  logic        bad_reserved;
  logic        rd_bad;
  ptid_pkg::result_t res;

  assign sel          = instr_word[24:20];
  assign rn           = instr_word[19:16];
  assign rd           = instr_word[11:8];
  assign imm12        = {instr_word[26], instr_word[14:12], instr_word[7:0]};
  assign bf_lsb       = {instr_word[14:12], instr_word[7:6]};
  assign bf_msb       = instr_word[4:0];
  assign sx_width     = {1'b0, instr_word[4:0]} + 6'd1;
  assign sx_end       = {2'b00, bf_lsb} + {1'b0, sx_width};
  assign bf_width     = {1'b0, bf_msb} - {1'b0, bf_lsb} + 6'd1;
  assign adr_base     = {fetch_addr[31:2] + 30'd1, 2'b00};
  assign bf_mask      = (32'hFFFF_FFFF >> (5'd31 - bf_msb)) & (32'hFFFF_FFFF << bf_lsb);
  assign bad_reserved = instr_word[26] | instr_word[5];
  assign rd_bad       = (rd == ptid_pkg::REG_SP) || (rd == ptid_pkg::REG_PC);

  always_comb begin
    res        = '0;
    res.status = ptid_pkg::ST_UNDEF;
    unique case (sel) inside
      ptid_pkg::SEL_ADD, ptid_pkg::SEL_SUB: begin
        if (rn == ptid_pkg::REG_PC) begin
          // PC-relative address generation, reported as a wide move.
          if (!rd_bad) begin
            res.status     = ptid_pkg::ST_OK;
            res.place_kind = ptid_pkg::K_MOVW;
            res.dest_reg   = rd;
            res.immediate  = (sel == ptid_pkg::SEL_ADD) ? adr_base + {20'd0, imm12}
                                                        : adr_base - {20'd0, imm12};
          end
        end else if (!(rd == ptid_pkg::REG_PC ||
                       (rd == ptid_pkg::REG_SP && rn != ptid_pkg::REG_SP))) begin
          res.status     = ptid_pkg::ST_OK;
          res.place_kind = ptid_pkg::K_DP;
          res.dp_opcode  = (sel == ptid_pkg::SEL_ADD) ? ptid_pkg::DP_ADD : ptid_pkg::DP_SUB;
          res.dest_reg   = rd;
          res.src_reg    = rn;
          res.immediate  = {20'd0, imm12};
        end
      end
      ptid_pkg::SEL_MOVW, ptid_pkg::SEL_MOVT: begin
        if (!rd_bad) begin
          res.status     = ptid_pkg::ST_OK;
          res.place_kind = (sel == ptid_pkg::SEL_MOVW) ? ptid_pkg::K_MOVW : ptid_pkg::K_MOVT;
          res.dest_reg   = rd;
          res.immediate  = {16'd0, rn, imm12};
        end
      end
      ptid_pkg::SEL_SBFX, ptid_pkg::SEL_UBFX: begin
        if (!bad_reserved && !rd_bad && rn != ptid_pkg::REG_SP &&
            rn != ptid_pkg::REG_PC && sx_end <= ptid_pkg::WORD_BITS) begin
          res.status      = ptid_pkg::ST_OK;
          res.place_kind  = (sel == ptid_pkg::SEL_SBFX) ? ptid_pkg::K_SBFX
                                                        : ptid_pkg::K_UBFX;
          res.dest_reg    = rd;
          res.src_reg     = rn;
          res.field_lsb   = bf_lsb;
          res.field_width = sx_width;
        end
      end
      ptid_pkg::SEL_BFI: begin
        if (!bad_reserved && !rd_bad && rn != ptid_pkg::REG_SP && bf_msb >= bf_lsb) begin
          res.status      = ptid_pkg::ST_OK;
          res.place_kind  = (rn == ptid_pkg::REG_PC) ? ptid_pkg::K_BFC : ptid_pkg::K_BFI;
          res.dest_reg    = rd;
          res.src_reg     = rn;
          res.field_lsb   = bf_lsb;
          res.field_width = bf_width;
          res.immediate   = bf_mask;
        end
      end
      ptid_pkg::SEL_SSAT, ptid_pkg::SEL_SSAT16, ptid_pkg::SEL_USAT,
      ptid_pkg::SEL_USAT16: begin
        res.status = ptid_pkg::ST_SAT;
      end
      default: begin
        res.status = ptid_pkg::ST_UNDEF;
      end
    endcase
  end

  // Anything that did not decode reports its status and nothing else.
  always_comb begin
    result = '0;
    result.status = res.status;
    if (res.status == ptid_pkg::ST_OK) begin
      result = res;
    end
  end

endmodule

// File: tb/sv/tb_thumb2_plain_immediate_decoder.sv
`timescale 1ns / 1ps

module tb_thumb2_plain_immediate_decoder;

  // Op values in bits 24:20 that belong to no form; the decoder must call them undefined.
  localparam logic [4:0] SEL_UNLISTED_HI = 5'h1F;
  localparam logic [4:0] SEL_UNLISTED_LO = 5'h06;

  // Fixed leading bits of the 32-bit encoding: 11110 in bits 31:27 and a set bit 25.
  localparam logic [4:0] T32_PREFIX = 5'b11110;

  localparam int RANDOM_WORDS  = 1900;
  // The receiver holds off twice, long enough for both pipeline stages to fill.
  localparam int HOLD_FIRST    = 400;
  localparam int HOLD_SECOND   = 1500;
  localparam int HOLD_CYCLES   = 80;
  // Between these cycles neither side inserts random gaps.
  localparam int STEADY_START  = 800;
  localparam int STEADY_END    = 1200;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    logic [31:0] word;
    logic [31:0] addr;
  } fetch_item_t;

  logic clk;
  logic rst_n;

  ptid_in_if  instr_ch ();
  ptid_out_if result_ch ();

  thumb2_plain_immediate_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (instr_ch),
    .out_ch (result_ch)
  );

  // Words waiting to be offered, and decodes predicted for words already transferred.
  fetch_item_t       pending_words[$];
  ptid_pkg::result_t predicted_decodes[$];

  int          fail_count;
  int          results_seen;
  int          cycle_count;
  logic [7:0]  hold_left;
  logic        steady_window;

  assign steady_window = (cycle_count >= STEADY_START) && (cycle_count < STEADY_END);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Assembles a word of the plain binary immediate space from its fields.
  function automatic logic [31:0] mk_word(input logic [4:0] sel, input logic [3:0] rn,
                                          input logic [3:0] rd, input logic i_bit,
                                          input logic [2:0] imm3, input logic [7:0] low8);
    mk_word = {T32_PREFIX, i_bit, 1'b1, sel, rn, 1'b0, imm3, rd, low8};
  endfunction

  // Predicts the decoded record of one word. Fields a form does not write stay zero,
  // which also covers the undefined and saturate outcomes.
  function automatic ptid_pkg::result_t decode_plain_imm(input logic [31:0] w,
                                                         input logic [31:0] pc_addr);
    ptid_pkg::result_t r;
    logic [4:0]  sel;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic [11:0] imm12;
    logic [4:0]  lsb;
    logic [4:0]  msb;
    logic [5:0]  wd;
    logic [31:0] base;
    logic [63:0] mask;
    logic        reserved_set;
    r            = '0;
    r.status     = ptid_pkg::ST_UNDEF;
    sel          = w[24:20];
    rn           = w[19:16];
    rd           = w[11:8];
    imm12        = {w[26], w[14:12], w[7:0]};
    lsb          = {w[14:12], w[7:6]};
    msb          = w[4:0];
    reserved_set = w[26] | w[5];
    unique case (sel) inside
      ptid_pkg::SEL_ADD, ptid_pkg::SEL_SUB: begin
        if (rn == ptid_pkg::REG_PC) begin
          // ADR: word-aligned PC plus or minus the immediate, wrapping at 2^32.
          if (rd != ptid_pkg::REG_SP && rd != ptid_pkg::REG_PC) begin
            base         = (pc_addr + 32'd4) & ~32'd3;
            r.status     = ptid_pkg::ST_OK;
            r.place_kind = ptid_pkg::K_MOVW;
            r.dest_reg   = rd;
            r.immediate  = (sel == ptid_pkg::SEL_ADD) ? base + {20'd0, imm12}
                                                      : base - {20'd0, imm12};
          end
        end else if (!(rd == ptid_pkg::REG_PC ||
                       (rd == ptid_pkg::REG_SP && rn != ptid_pkg::REG_SP))) begin
          r.status     = ptid_pkg::ST_OK;
          r.place_kind = ptid_pkg::K_DP;
          r.dp_opcode  = (sel == ptid_pkg::SEL_ADD) ? ptid_pkg::DP_ADD : ptid_pkg::DP_SUB;
          r.dest_reg   = rd;
          r.src_reg    = rn;
          r.immediate  = {20'd0, imm12};
        end
      end
      ptid_pkg::SEL_MOVW, ptid_pkg::SEL_MOVT: begin
        if (rd != ptid_pkg::REG_SP && rd != ptid_pkg::REG_PC) begin
          r.status     = ptid_pkg::ST_OK;
          r.place_kind = (sel == ptid_pkg::SEL_MOVW) ? ptid_pkg::K_MOVW : ptid_pkg::K_MOVT;
          r.dest_reg   = rd;
          r.immediate  = {16'd0, rn, imm12};
        end
      end
      ptid_pkg::SEL_SBFX, ptid_pkg::SEL_UBFX: begin
        wd = {1'b0, msb} + 6'd1;
        if (!reserved_set && rd != ptid_pkg::REG_SP && rd != ptid_pkg::REG_PC &&
            rn != ptid_pkg::REG_SP && rn != ptid_pkg::REG_PC &&
            ({2'b00, lsb} + {1'b0, wd}) <= ptid_pkg::WORD_BITS) begin
          r.status      = ptid_pkg::ST_OK;
          r.place_kind  = (sel == ptid_pkg::SEL_SBFX) ? ptid_pkg::K_SBFX : ptid_pkg::K_UBFX;
          r.dest_reg    = rd;
          r.src_reg     = rn;
          r.field_lsb   = lsb;
          r.field_width = wd;
        end
      end
      ptid_pkg::SEL_BFI: begin
        if (!reserved_set && rd != ptid_pkg::REG_SP && rd != ptid_pkg::REG_PC &&
            rn != ptid_pkg::REG_SP && msb >= lsb) begin
          wd            = {1'b0, msb} - {1'b0, lsb} + 6'd1;
          mask          = ((64'd1 << wd) - 64'd1) << lsb;
          r.status      = ptid_pkg::ST_OK;
          r.place_kind  = (rn == ptid_pkg::REG_PC) ? ptid_pkg::K_BFC : ptid_pkg::K_BFI;
          r.dest_reg    = rd;
          r.src_reg     = rn;
          r.field_lsb   = lsb;
          r.field_width = wd;
          r.immediate   = mask[31:0];
        end
      end
      ptid_pkg::SEL_SSAT, ptid_pkg::SEL_SSAT16, ptid_pkg::SEL_USAT,
      ptid_pkg::SEL_USAT16: begin
        r.status = ptid_pkg::ST_SAT;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic add_word(input logic [31:0] word, input logic [31:0] addr);
    fetch_item_t item;
    item.word = word;
    item.addr = addr;
    pending_words.push_back(item);
  endtask

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what);
    fail_count++;
    $display("MISMATCH at result %0d: %s", results_seen, what);
  endtask

  task automatic compare_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  // The long receiver hold-off is timed here, in cycles, apart from the handshake logic.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= '0;
    end else if (cycle_count == HOLD_FIRST || cycle_count == HOLD_SECOND) begin
      hold_left <= 8'(HOLD_CYCLES);
    end else if (hold_left != 8'd0) begin
      hold_left <= hold_left - 8'd1;
    end
  end

  // Driver. At each edge it first records the prediction for a word that transferred,
  // then decides what to offer next. Valid gets at most one assignment per edge, so a word
  // that follows directly keeps valid high without a glitch. While the receiver holds off
  // the sender keeps offering, which is what backs the pipeline up into the input side.
  always @(posedge clk) begin : drive_words
    fetch_item_t next_item;
    if (!rst_n) begin
      instr_ch.valid <= 1'b0;
    end else begin
      if (instr_ch.valid && instr_ch.ready) begin
        predicted_decodes.push_back(decode_plain_imm(instr_ch.instr_word,
                                                     instr_ch.fetch_addr));
      end
      if (!instr_ch.valid || instr_ch.ready) begin
        if (pending_words.size() != 0 &&
            (steady_window || hold_left != 8'd0 || $urandom_range(0, 99) >= 15)) begin
          next_item            = pending_words.pop_front();
          instr_ch.valid      <= 1'b1;
          instr_ch.instr_word <= next_item.word;
          instr_ch.fetch_addr <= next_item.addr;
        end else begin
          instr_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result that transfers is checked field by field against the oldest
  // prediction; a result that arrives with nothing predicted is a failure of its own.
  always @(posedge clk) begin : check_results
    ptid_pkg::result_t want;
    if (!rst_n) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (predicted_decodes.size() == 0) begin
          report_mismatch("result with no word outstanding");
        end else begin
          want = predicted_decodes.pop_front();
          compare_field("status", 32'(result_ch.status), 32'(want.status));
          compare_field("place_kind", 32'(result_ch.place_kind), 32'(want.place_kind));
          compare_field("dp_opcode", 32'(result_ch.dp_opcode), 32'(want.dp_opcode));
          compare_field("dest_reg", 32'(result_ch.dest_reg), 32'(want.dest_reg));
          compare_field("src_reg", 32'(result_ch.src_reg), 32'(want.src_reg));
          compare_field("immediate", result_ch.immediate, want.immediate);
          compare_field("field_lsb", 32'(result_ch.field_lsb), 32'(want.field_lsb));
          compare_field("field_width", 32'(result_ch.field_width), 32'(want.field_width));
        end
        results_seen++;
      end
      result_ch.ready <= (hold_left == 8'd0) &&
                         (steady_window || $urandom_range(0, 99) >= 15);
    end
  end

  initial begin : run_test
    logic [31:0] word;
    logic [31:0] addr;
    logic [4:0]  sel;
    int          lsb;
    int          hi;
    fail_count           = 0;
    results_seen         = 0;
    rst_n                = 1'b0;
    instr_ch.valid       = 1'b0;
    instr_ch.instr_word  = '0;
    instr_ch.fetch_addr  = '0;
    result_ch.ready      = 1'b0;

    // Directed words: immediate extremes, each form, and the register and field checks.
    add_word(mk_word(ptid_pkg::SEL_ADD, 4'd0, 4'd0, 1'b0, 3'd0, 8'h00), 32'h0000_0000);
    add_word(mk_word(ptid_pkg::SEL_ADD, 4'd14, 4'd14, 1'b1, 3'd7, 8'hFF), 32'hFFFF_FFFF);
    add_word(mk_word(ptid_pkg::SEL_SUB, 4'd7, 4'd3, 1'b0, 3'd5, 8'h5A), 32'h1234_5678);
    // SP as destination is legal only when SP is also the source.
    add_word(mk_word(ptid_pkg::SEL_ADD, ptid_pkg::REG_SP, ptid_pkg::REG_SP, 1'b0, 3'd1,
                     8'h10), 32'h0000_1000);
    add_word(mk_word(ptid_pkg::SEL_SUB, 4'd2, ptid_pkg::REG_SP, 1'b0, 3'd1, 8'h10),
             32'h0000_1000);
    add_word(mk_word(ptid_pkg::SEL_ADD, 4'd2, ptid_pkg::REG_PC, 1'b0, 3'd0, 8'h01),
             32'h0000_1000);
    // ADR forms, with the address wrapping past the top and below zero.
    add_word(mk_word(ptid_pkg::SEL_ADD, ptid_pkg::REG_PC, 4'd1, 1'b1, 3'd7, 8'hFF),
             32'hFFFF_FFFE);
    add_word(mk_word(ptid_pkg::SEL_SUB, ptid_pkg::REG_PC, 4'd2, 1'b1, 3'd7, 8'hFF),
             32'h0000_0000);
    add_word(mk_word(ptid_pkg::SEL_ADD, ptid_pkg::REG_PC, ptid_pkg::REG_SP, 1'b0, 3'd0,
                     8'h04), 32'h0000_2002);
    // Wide moves, with the largest and smallest immediates.
    add_word(mk_word(ptid_pkg::SEL_MOVW, 4'hF, 4'd0, 1'b1, 3'd7, 8'hFF), 32'h0000_0040);
    add_word(mk_word(ptid_pkg::SEL_MOVT, 4'h0, 4'd14, 1'b0, 3'd0, 8'h00), 32'h0000_0044);
    add_word(mk_word(ptid_pkg::SEL_MOVT, 4'h3, ptid_pkg::REG_PC, 1'b0, 3'd0, 8'h00),
             32'h0000_0048);
    // Bitfield extracts: full width, top bit, overflow past bit 31, reserved bits, bad Rn.
    add_word(mk_word(ptid_pkg::SEL_SBFX, 4'd0, 4'd0, 1'b0, 3'd0, 8'h1F), 32'h0000_0050);
    add_word(mk_word(ptid_pkg::SEL_UBFX, 4'd14, 4'd14, 1'b0, 3'd7, 8'hC0), 32'h0000_0054);
    add_word(mk_word(ptid_pkg::SEL_UBFX, 4'd1, 4'd1, 1'b0, 3'd7, 8'hC1), 32'h0000_0058);
    add_word(mk_word(ptid_pkg::SEL_SBFX, 4'd1, 4'd1, 1'b1, 3'd0, 8'h03), 32'h0000_005C);
    add_word(mk_word(ptid_pkg::SEL_SBFX, 4'd1, 4'd1, 1'b0, 3'd0, 8'h23), 32'h0000_0060);
    add_word(mk_word(ptid_pkg::SEL_SBFX, ptid_pkg::REG_PC, 4'd1, 1'b0, 3'd0, 8'h03),
             32'h0000_0064);
    // Bitfield inserts: full mask, a clear of one bit, msb below lsb, SP as source.
    add_word(mk_word(ptid_pkg::SEL_BFI, 4'd3, 4'd4, 1'b0, 3'd0, 8'h1F), 32'h0000_0068);
    add_word(mk_word(ptid_pkg::SEL_BFI, ptid_pkg::REG_PC, 4'd5, 1'b0, 3'd1, 8'h45),
             32'h0000_006C);
    add_word(mk_word(ptid_pkg::SEL_BFI, 4'd3, 4'd4, 1'b0, 3'd1, 8'h44), 32'h0000_0070);
    add_word(mk_word(ptid_pkg::SEL_BFI, ptid_pkg::REG_SP, 4'd4, 1'b0, 3'd0, 8'h07),
             32'h0000_0074);
    // Saturate encodings and op values outside every form.
    add_word(mk_word(ptid_pkg::SEL_SSAT, 4'd1, 4'd2, 1'b0, 3'd0, 8'h07), 32'h0000_0078);
    add_word(mk_word(ptid_pkg::SEL_SSAT16, 4'd1, 4'd2, 1'b0, 3'd0, 8'h07), 32'h0000_007C);
    add_word(mk_word(ptid_pkg::SEL_USAT, 4'd1, 4'd2, 1'b0, 3'd0, 8'h07), 32'h0000_0080);
    add_word(mk_word(ptid_pkg::SEL_USAT16, 4'd1, 4'd2, 1'b0, 3'd0, 8'h07), 32'h0000_0084);
    add_word(mk_word(SEL_UNLISTED_HI, 4'd1, 4'd2, 1'b0, 3'd0, 8'h07), 32'h0000_0088);
    add_word(mk_word(SEL_UNLISTED_LO, 4'd1, 4'd2, 1'b0, 3'd0, 8'h07), 32'h0000_008C);

    // Random words. Most carry a listed op with random content, shaped so that bitfield
    // geometry is usually legal and ADR and BFC turn up often; one in five is pure noise,
    // which also toggles the bits outside the decoded fields.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      addr = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        addr = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
      end
      word = $urandom;
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 10))
          0:       sel = ptid_pkg::SEL_ADD;
          1:       sel = ptid_pkg::SEL_SUB;
          2:       sel = ptid_pkg::SEL_MOVW;
          3:       sel = ptid_pkg::SEL_MOVT;
          4:       sel = ptid_pkg::SEL_SBFX;
          5:       sel = ptid_pkg::SEL_UBFX;
          6:       sel = ptid_pkg::SEL_BFI;
          7:       sel = ptid_pkg::SEL_SSAT;
          8:       sel = ptid_pkg::SEL_SSAT16;
          9:       sel = ptid_pkg::SEL_USAT;
          default: sel = ptid_pkg::SEL_USAT16;
        endcase
        word[24:20] = sel;
        if ((sel == ptid_pkg::SEL_ADD || sel == ptid_pkg::SEL_SUB) &&
            $urandom_range(0, 3) == 0) begin
          word[19:16] = ptid_pkg::REG_PC;
        end
        if (sel == ptid_pkg::SEL_BFI && $urandom_range(0, 2) == 0) begin
          word[19:16] = ptid_pkg::REG_PC;
        end
        if ((sel == ptid_pkg::SEL_SBFX || sel == ptid_pkg::SEL_UBFX ||
             sel == ptid_pkg::SEL_BFI) && $urandom_range(0, 3) != 0) begin
          word[26]    = 1'b0;
          word[5]     = 1'b0;
          lsb         = $urandom_range(0, 31);
          hi          = (sel == ptid_pkg::SEL_BFI) ? $urandom_range(lsb, 31)
                                                   : $urandom_range(0, 31 - lsb);
          word[14:12] = lsb[4:2];
          word[7:6]   = lsb[1:0];
          word[4:0]   = hi[4:0];
        end
      end
      add_word(word, addr);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word has transferred, then until every prediction has been met.
    while (pending_words.size() != 0 || instr_ch.valid !== 1'b0) @(posedge clk);
    while (predicted_decodes.size() != 0) @(posedge clk);
    // A final drain wait catches any result the block offers beyond those predicted.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("thumb2_plain_immediate_decoder verification clean");
    end else begin
      $display("thumb2_plain_immediate_decoder verification failed");
    end
    $finish;
  end

  // Safety net against a hung handshake; far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("thumb2_plain_immediate_decoder verification failed");
    $finish;
  end

endmodule
